// ===== rtl/core/ukpf_pkg.sv =====
package ukpf_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  localparam int POS_BITS    = 16;
  localparam int LINK_BITS   = 5;
  localparam int PORT_BITS   = 16;
  localparam int CFG_BITS    = 16;

  // header layout, relative to the start of the ip header
  localparam int OFS_PROTO    = 9;
  localparam int OFS_SRC_LO   = 12;
  localparam int OFS_SRC_HI   = 15;
  localparam int OFS_PORT_LO  = 22;
  localparam int OFS_PORT_HI  = 23;
  localparam int OFS_ULEN_LO  = 24;
  localparam int OFS_ULEN_HI  = 25;
  localparam int OFS_PAYLOAD  = 28;

  localparam int UDP_PROTO    = 17;
  localparam int UDP_HDR      = 8;
  localparam int MIN_PAYLOAD  = 6;
  localparam int USER_SLACK   = 5;

  localparam int MID_DEPTH    = 4;
  localparam int OUT_DEPTH    = 2;

  typedef enum logic [0:0] {
    CFG_LINK_HEADER = 1'b0,
    CFG_KNOCK_PORT  = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    REJ_OK         = 3'd0,
    REJ_NOT_UDP    = 3'd1,
    REJ_WRONG_PORT = 3'd2,
    REJ_TRUNCATED  = 3'd3,
    REJ_SHORT      = 3'd4,
    REJ_BAD_USER   = 3'd5,
    REJ_NO_COLON   = 3'd6,
    REJ_BAD_ENC    = 3'd7
  } reject_t;

  typedef enum logic [2:0] {
    PH_USER     = 3'd0,
    PH_ENC      = 3'd1,
    PH_PAD      = 3'd2,
    PH_USER_BAD = 3'd3,
    PH_ENC_BAD  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_PROTO   = 3'd1,
    K_SRC     = 3'd2,
    K_PORT    = 3'd3,
    K_ULEN    = 3'd4,
    K_PAYLOAD = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic        knock_ok;
    logic [2:0]  reject_code;
    logic [31:0] source_address;
    logic [15:0] user_length;
    logic [15:0] encoded_length;
  } result_t;

  typedef struct packed {
    logic user_char;
    logic enc_char;
    logic colon;
    logic equal;
  } char_class_t;

  typedef struct packed {
    logic [7:0]  byte_val;
    kind_t       kind;
    char_class_t cls;
    logic        last;
    logic        long_enough;
  } entry_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.user_char = is_alnum(c) || c == 8'h5f || c == 8'h40 || c == 8'h2e;
    r.enc_char  = is_alnum(c) || c == 8'h2b || c == 8'h2f;
    r.colon     = c == 8'h3a;
    r.equal     = c == 8'h3d;
    return r;
  endfunction

endpackage

// ===== rtl/core/ukpf_queue.sv =====
module ukpf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [IDX_BITS-1:0] wr_ptr;
  logic [IDX_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = count == CNT_BITS'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  function automatic logic [IDX_BITS-1:0] bump(input logic [IDX_BITS-1:0] p);
    return (p == IDX_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ukpf_front.sv =====
module ukpf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ukpf_pkg::LINK_BITS-1:0]    link_header_bytes,
  input  logic                              take,
  input  ukpf_pkg::in_item_t                item,
  output ukpf_pkg::entry_t                  ent
);
  import ukpf_pkg::*;

  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] pos_adv;
  logic [POS_BITS-1:0] rel;
  logic [POS_BITS-1:0] link_ext;
  logic                sat;
  logic                in_hdr;

  assign link_ext = POS_BITS'(link_header_bytes);
  assign sat      = pos == {POS_BITS{1'b1}};
  assign pos_adv  = sat ? pos : pos + 1'b1;
  assign rel      = pos - link_ext;
  assign in_hdr   = !sat && (pos >= link_ext);

  always_comb begin
    ent.byte_val    = item.frame_byte;
    ent.last        = item.frame_last;
    ent.cls         = classify(item.frame_byte);
    ent.long_enough = pos_adv >= (link_ext + POS_BITS'(OFS_PAYLOAD));
    ent.kind        = K_NONE;
    if (in_hdr) begin
      if (rel == POS_BITS'(OFS_PROTO)) begin
        ent.kind = K_PROTO;
      end else if (rel >= POS_BITS'(OFS_SRC_LO) && rel <= POS_BITS'(OFS_SRC_HI)) begin
        ent.kind = K_SRC;
      end else if (rel == POS_BITS'(OFS_PORT_LO) || rel == POS_BITS'(OFS_PORT_HI)) begin
        ent.kind = K_PORT;
      end else if (rel == POS_BITS'(OFS_ULEN_LO) || rel == POS_BITS'(OFS_ULEN_HI)) begin
        ent.kind = K_ULEN;
      end else if (rel >= POS_BITS'(OFS_PAYLOAD)) begin
        ent.kind = K_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      pos <= item.frame_last ? '0 : pos_adv;
    end
  end

endmodule

// ===== rtl/core/ukpf_back.sv =====
module ukpf_back #(
  parameter int LENGTH_BITS = ukpf_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ukpf_pkg::PORT_BITS-1:0] knock_port,
  input  ukpf_pkg::entry_t               ent,
  input  logic                           ent_valid,
  output logic                           ent_pop,
  output ukpf_pkg::result_t              res,
  output logic                           res_push,
  input  logic                           res_full
);
  import ukpf_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  logic [7:0]             proto, proto_next;
  logic [31:0]            src, src_next;
  logic [15:0]            port, port_next;
  logic [15:0]            ulen, ulen_next;
  phase_t                 phase, phase_next;
  logic [LENGTH_BITS-1:0] user_cnt, user_cnt_next;
  logic [LENGTH_BITS-1:0] enc_cnt, enc_cnt_next;
  logic [LENGTH_BITS-1:0] pay_cnt, pay_cnt_next;
  logic                   clamped;
  logic                   fire;
  reject_t                code;

  assign fire     = ent_valid && (!ent.last || !res_full);
  assign ent_pop  = fire;
  assign res_push = fire && ent.last;

  assign clamped = (ulen >= 16'(UDP_HDR)) && (16'(pay_cnt) >= ulen - 16'(UDP_HDR));

  always_comb begin
    proto_next    = proto;
    src_next      = src;
    port_next     = port;
    ulen_next     = ulen;
    phase_next    = phase;
    user_cnt_next = user_cnt;
    enc_cnt_next  = enc_cnt;
    pay_cnt_next  = pay_cnt;
    case (ent.kind)
      K_PROTO: proto_next = ent.byte_val;
      K_SRC:   src_next   = {src[23:0], ent.byte_val};
      K_PORT:  port_next  = {port[7:0], ent.byte_val};
      K_ULEN:  ulen_next  = {ulen[7:0], ent.byte_val};
      K_PAYLOAD: begin
        if (!clamped && pay_cnt != LEN_MAX) begin
          pay_cnt_next = pay_cnt + 1'b1;
          case (phase)
            PH_USER: begin
              if (ent.cls.user_char) begin
                user_cnt_next = user_cnt + 1'b1;
              end else if (ent.cls.colon && user_cnt != '0) begin
                phase_next = PH_ENC;
              end else begin
                phase_next = PH_USER_BAD;
              end
            end
            PH_ENC: begin
              if (!ent.cls.enc_char) begin
                phase_next = (ent.cls.equal && enc_cnt != '0) ? PH_PAD : PH_ENC_BAD;
              end
              enc_cnt_next = enc_cnt + 1'b1;
            end
            PH_PAD: begin
              if (!ent.cls.equal) begin
                phase_next = PH_ENC_BAD;
              end
              enc_cnt_next = enc_cnt + 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // verdict over the state as it stands after the last byte
  always_comb begin
    if (proto_next != 8'(UDP_PROTO)) begin
      code = REJ_NOT_UDP;
    end else if (port_next != knock_port) begin
      code = REJ_WRONG_PORT;
    end else if (!ent.long_enough) begin
      code = REJ_TRUNCATED;
    end else if (pay_cnt_next < LENGTH_BITS'(MIN_PAYLOAD)) begin
      code = REJ_SHORT;
    end else if (user_cnt_next == '0) begin
      code = REJ_BAD_USER;
    end else if (user_cnt_next > pay_cnt_next - LENGTH_BITS'(USER_SLACK)) begin
      code = REJ_NO_COLON;
    end else if (phase_next == PH_USER_BAD) begin
      code = REJ_BAD_USER;
    end else if (phase_next == PH_USER) begin
      code = REJ_NO_COLON;
    end else if (phase_next == PH_ENC_BAD || enc_cnt_next == '0) begin
      code = REJ_BAD_ENC;
    end else begin
      code = REJ_OK;
    end
  end

  always_comb begin
    res.knock_ok       = code == REJ_OK;
    res.reject_code    = code;
    res.source_address = src_next;
    res.user_length    = (code == REJ_OK) ? 16'(user_cnt_next) : '0;
    res.encoded_length = (code == REJ_OK) ? 16'(enc_cnt_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proto    <= '0;
      src      <= '0;
      port     <= '0;
      ulen     <= '0;
      phase    <= PH_USER;
      user_cnt <= '0;
      enc_cnt  <= '0;
      pay_cnt  <= '0;
    end else if (fire) begin
      if (ent.last) begin
        proto    <= '0;
        src      <= '0;
        port     <= '0;
        ulen     <= '0;
        phase    <= PH_USER;
        user_cnt <= '0;
        enc_cnt  <= '0;
        pay_cnt  <= '0;
      end else begin
        proto    <= proto_next;
        src      <= src_next;
        port     <= port_next;
        ulen     <= ulen_next;
        phase    <= phase_next;
        user_cnt <= user_cnt_next;
        enc_cnt  <= enc_cnt_next;
        pay_cnt  <= pay_cnt_next;
      end
    end
  end

  a_push_on_last: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (ent_valid && ent.last))
    else $error("verdict without a last byte");

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (pay_cnt == '0 && user_cnt == '0 && enc_cnt == '0 && phase == PH_USER))
    else $error("frame state not cleared after verdict");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (user_cnt <= pay_cnt) && (enc_cnt <= pay_cnt))
    else $error("name counts exceed payload count");

endmodule

// ===== rtl/core/udp_knock_packet_filter_core.sv =====
// a verdict passes the byte queue and then the result queue before it shows on out_item
// throughput: one frame byte per cycle while full stays low, one verdict per frame at its last byte
// the front keeps the byte position; the back holds frame state and judges each frame
// full only rises when the 4-deep byte queue backs up behind a stalled result queue
// rst (synchronous) empties both queues, clears frame state, link offset 14, port 0
module udp_knock_packet_filter_core #(
  parameter int LENGTH_BITS = ukpf_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // byte requests in
  input  logic                          push,
  input  ukpf_pkg::in_item_t            in_item,
  output logic                          full,
  // verdict requests out
  output logic                          empty,
  input  logic                          pop,
  output ukpf_pkg::result_t             out_item,
  // register writes
  input  logic                          cfg_write,
  input  ukpf_pkg::cfg_index_t          cfg_index,
  input  logic [ukpf_pkg::CFG_BITS-1:0] cfg_data
);
  import ukpf_pkg::*;

  logic [LINK_BITS-1:0] link_header_bytes;
  logic [PORT_BITS-1:0] knock_port;

  entry_t  front_ent;
  entry_t  back_ent;
  logic    take;
  logic    mid_empty;
  logic    mid_pop;
  result_t verdict;
  logic    verdict_push;
  logic    out_full;

  // config registers; the user writes them only while no frame is in flight, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      link_header_bytes <= LINK_BITS'(14);
      knock_port        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LINK_HEADER: link_header_bytes <= cfg_data[LINK_BITS-1:0];
        CFG_KNOCK_PORT:  knock_port        <= cfg_data[PORT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign take = push && !full;

  // front: position tracking and per-byte tagging
  ukpf_front u_front (
    .clk               (clk),
    .rst               (rst),
    .link_header_bytes (link_header_bytes),
    .take              (take),
    .item              (in_item),
    .ent               (front_ent)
  );

  // tagged bytes wait here so the back can stall on its own
  ukpf_queue #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_ent),
    .full  (full),
    .pop   (mid_pop),
    .rdata (back_ent),
    .empty (mid_empty)
  );

  // back: frame state, payload grammar and verdict
  ukpf_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .knock_port (knock_port),
    .ent        (back_ent),
    .ent_valid  (!mid_empty),
    .ent_pop    (mid_pop),
    .res        (verdict),
    .res_push   (verdict_push),
    .res_full   (out_full)
  );

  // verdicts wait here until popped
  ukpf_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (verdict_push),
    .wdata (verdict),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );

endmodule

// ===== bench/knock_verdict_checker.sv =====
`timescale 1ns / 100ps

module knock_verdict_checker #(
  parameter int LENGTH_BITS = ukpf_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  ukpf_pkg::in_item_t            in_item,
  input  logic                          empty,
  input  logic                          pop,
  input  ukpf_pkg::result_t             out_item,
  input  logic                          cfg_write,
  input  ukpf_pkg::cfg_index_t          cfg_index,
  input  logic [ukpf_pkg::CFG_BITS-1:0] cfg_data,
  output int                            outstanding,
  output int                            fail_count
);
  import ukpf_pkg::*;

  localparam int POS_CAP     = 65535;
  localparam int PAYLOAD_CAP = (1 << LENGTH_BITS) - 1;
  localparam logic [4:0] LINK_RESET = 5'd14;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // register copies
  logic [4:0]  link_ofs;
  logic [15:0] port_want;

  // frame state
  int          frame_pos;
  logic [7:0]  proto_got;
  logic [15:0] dport_got;
  logic [15:0] udp_len_got;
  logic [31:0] src_got;
  phase_t      phase;
  int          user_cnt;
  int          code_cnt;
  int          pay_cnt;

  result_t     verdicts_due[$];
  result_t     want;
  int          fails = 0;
  int          due_level = 0;

  assign fail_count  = fails;
  assign outstanding = due_level;

  function automatic bit word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  task automatic clear_frame();
    frame_pos   = 0;
    proto_got   = '0;
    dport_got   = '0;
    udp_len_got = '0;
    src_got     = '0;
    phase       = PH_USER;
    user_cnt    = 0;
    code_cnt    = 0;
    pay_cnt     = 0;
  endtask

  task automatic take_payload_byte(input logic [7:0] c);
    case (phase)
      PH_USER: begin
        if (word_char(c) || c == CH_UNDER || c == CH_AT || c == CH_DOT) user_cnt++;
        else if (c == CH_COLON && user_cnt != 0) phase = PH_ENC;
        else phase = PH_USER_BAD;
      end
      PH_ENC: begin
        if (!(word_char(c) || c == CH_PLUS || c == CH_SLASH)) begin
          if (c == CH_EQUAL && code_cnt != 0) phase = PH_PAD;
          else phase = PH_ENC_BAD;
        end
        code_cnt++;
      end
      PH_PAD: begin
        if (c != CH_EQUAL) phase = PH_ENC_BAD;
        code_cnt++;
      end
      default: ;
    endcase
  endtask

  function automatic reject_t grade_frame();
    if (proto_got != UDP_PROTO) return REJ_NOT_UDP;
    if (dport_got != port_want) return REJ_WRONG_PORT;
    if (frame_pos < int'(link_ofs) + OFS_PAYLOAD) return REJ_TRUNCATED;
    if (pay_cnt < MIN_PAYLOAD) return REJ_SHORT;
    if (user_cnt == 0) return REJ_BAD_USER;
    if (user_cnt > pay_cnt - USER_SLACK) return REJ_NO_COLON;
    if (phase == PH_USER_BAD) return REJ_BAD_USER;
    if (phase == PH_USER) return REJ_NO_COLON;
    if (phase == PH_ENC_BAD) return REJ_BAD_ENC;
    if (code_cnt == 0) return REJ_BAD_ENC;
    return REJ_OK;
  endfunction

  task automatic absorb_frame_byte(input logic [7:0] b, input logic last);
    int      rel;
    bit      clamped;
    reject_t code;
    result_t r;
    if (frame_pos < POS_CAP) begin
      if (frame_pos >= int'(link_ofs)) begin
        rel = frame_pos - int'(link_ofs);
        if (rel == OFS_PROTO) proto_got = b;
        else if (rel >= OFS_SRC_LO && rel <= OFS_SRC_HI) src_got = {src_got[23:0], b};
        else if (rel == OFS_PORT_LO || rel == OFS_PORT_HI) dport_got = {dport_got[7:0], b};
        else if (rel == OFS_ULEN_LO || rel == OFS_ULEN_HI) udp_len_got = {udp_len_got[7:0], b};
        else if (rel >= OFS_PAYLOAD) begin
          clamped = int'(udp_len_got) >= UDP_HDR && pay_cnt >= int'(udp_len_got) - UDP_HDR;
          if (!clamped && pay_cnt < PAYLOAD_CAP) begin
            take_payload_byte(b);
            pay_cnt++;
          end
        end
      end
      frame_pos++;
    end
    if (last) begin
      code             = grade_frame();
      r.knock_ok       = (code == REJ_OK);
      r.reject_code    = code;
      r.source_address = src_got;
      r.user_length    = (code == REJ_OK) ? 16'(user_cnt) : 16'd0;
      r.encoded_length = (code == REJ_OK) ? 16'(code_cnt) : 16'd0;
      verdicts_due.push_back(r);
      clear_frame();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: %s mismatch, got %0h want %0h", $realtime, what, got, exp_val);
    fails++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      link_ofs  = LINK_RESET;
      port_want = '0;
      clear_frame();
      verdicts_due.delete();
    end else begin
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unrequested verdict", 32'(out_item.reject_code), '0);
        end else begin
          want = verdicts_due.pop_front();
          if (out_item.knock_ok !== want.knock_ok)
            report_mismatch("knock_ok", 32'(out_item.knock_ok), 32'(want.knock_ok));
          if (out_item.reject_code !== want.reject_code)
            report_mismatch("reject_code", 32'(out_item.reject_code), 32'(want.reject_code));
          if (out_item.source_address !== want.source_address)
            report_mismatch("source_address", out_item.source_address, want.source_address);
          if (out_item.user_length !== want.user_length)
            report_mismatch("user_length", 32'(out_item.user_length), 32'(want.user_length));
          if (out_item.encoded_length !== want.encoded_length)
            report_mismatch("encoded_length", 32'(out_item.encoded_length),
                            32'(want.encoded_length));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_LINK_HEADER: link_ofs = cfg_data[LINK_BITS-1:0];
          CFG_KNOCK_PORT:  port_want = cfg_data[PORT_BITS-1:0];
          default: ;
        endcase
      end
      if (push && !full) absorb_frame_byte(in_item.frame_byte, in_item.frame_last);
    end
    due_level <= verdicts_due.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ukpf_pkg::*;

  // frame shapes the generator can build
  typedef enum int {
    F_NONE,
    F_CLAMP,
    F_GARBAGE,
    F_NOISE,
    F_PROTO,
    F_PORT,
    F_TRUNC,
    F_SHORT,
    F_EMPTY_USER,
    F_LONG_USER,
    F_USER_CHAR,
    F_NO_COLON,
    F_ENC_CHAR,
    F_EQ_FIRST,
    F_PAD_BREAK,
    F_EMPTY_ENC,
    F_HUGE
  } flaw_t;

  localparam string WORD_SET = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
  localparam string USER_SET = {WORD_SET, "_@."};
  localparam string CODE_SET = {WORD_SET, "+/"};
  localparam string NOT_USER = "!#$%&*+,-/;<=>?[]^`{|}~ \"'()";
  localparam string NOT_CODE = "!#$%&*,-.:;<>?@[]^_`{|}~ \"'()";
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam int HUGE_FRAME = 65600;
  localparam int PHASE_FRAMES = 12;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  in_item_t             in_item = '0;
  logic                 full;
  logic                 empty;
  logic                 pop = 1'b0;
  result_t              out_item;
  logic                 cfg_write = 1'b0;
  cfg_index_t           cfg_index = CFG_LINK_HEADER;
  logic [CFG_BITS-1:0]  cfg_data = '0;

  int                   outstanding;
  int                   fail_count;

  // stimulus bookkeeping
  logic [7:0]           frame_q[$];
  logic [4:0]           cur_link = 5'd14;
  logic [15:0]          cur_port = 16'd0;
  bit                   calm = 1'b0;      // no idling on either side while set
  int                   frames_sent = 0;
  int                   bytes_sent = 0;
  int                   phase_no;

  udp_knock_packet_filter_core dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  knock_verdict_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest legal run, long frame included
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: pop stalls at random, about 11 percent of the time, unless calm
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // a byte outside the given class, sometimes from the upper half of the code space
  function automatic logic [7:0] pick_bad(input string s);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(128, 255));
    return pick(s);
  endfunction

  // one byte request; push stays high on return so back-to-back bytes need no toggle
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(0, 99) < 11) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= '{frame_byte: b, frame_last: last};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
    bytes_sent += frame_q.size();
  endtask

  // hold the sender until every verdict due has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // both registers, written only with the block drained and settled
  task automatic set_config(input logic [4:0] link, input logic [15:0] port);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_LINK_HEADER;
    cfg_data  <= {11'($urandom_range(0, 2047)), link};   // upper bits must be ignored
    @(posedge clk);
    cfg_index <= CFG_KNOCK_PORT;
    cfg_data  <= port;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    cur_link = link;
    cur_port = port;
  endtask

  // builds one frame into frame_q: link header, ip header, udp header, user:code payload, or plain noise
  task automatic build_frame(input flaw_t flaw);
    logic [7:0]  pay[$];
    int          ucount;
    int          ecount;
    int          pcount;
    int          cut;
    logic [15:0] dport;
    logic [15:0] ulen;
    frame_q.delete();
    if (flaw == F_NOISE) begin
      repeat ($urandom_range(1, 60)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (cur_link) frame_q.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < 20; i++) begin
        if (i == OFS_PROTO)
          // any protocol byte but udp when flawed
          frame_q.push_back(flaw == F_PROTO ? 8'(($urandom_range(1, 255) + UDP_PROTO) % 256)
                                            : 8'(UDP_PROTO));
        else
          frame_q.push_back(8'($urandom_range(0, 255)));
      end

      ucount = (flaw == F_EMPTY_USER) ? 0 : (flaw == F_LONG_USER) ? 10 : $urandom_range(1, 8);
      ecount = (flaw == F_EMPTY_ENC) ? 0 : $urandom_range(1, 12);
      pcount = $urandom_range(0, 2);
      if (flaw == F_SHORT) begin
        ucount = $urandom_range(1, 2);
        ecount = 1;
        pcount = $urandom_range(0, 1);
      end
      if (flaw == F_HUGE) begin
        ucount = 1;
        pcount = 0;
        ecount = HUGE_FRAME - (cur_link + OFS_PAYLOAD) - 2;
      end

      if (flaw == F_GARBAGE) begin
        repeat ($urandom_range(6, 20)) pay.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat (ucount) pay.push_back(pick(USER_SET));
        if (flaw != F_NO_COLON) pay.push_back(CH_COLON);
        repeat (ecount) pay.push_back(pick(CODE_SET));
        repeat (pcount) pay.push_back(CH_EQUAL);
        case (flaw)
          F_USER_CHAR: pay[$urandom_range(0, ucount - 1)] = pick_bad(NOT_USER);
          F_ENC_CHAR:  pay[ucount + 1 + $urandom_range(0, ecount - 1)] = pick_bad(NOT_CODE);
          F_EQ_FIRST:  pay[ucount + 1] = CH_EQUAL;
          F_PAD_BREAK: begin
            if (pcount == 0) pay.push_back(CH_EQUAL);
            pay.push_back(pick(CODE_SET));
          end
          default: ;
        endcase
      end

      dport = cur_port;
      if (flaw == F_PORT) dport = cur_port ^ 16'($urandom_range(1, 65535));

      ulen = 16'(pay.size() + UDP_HDR);
      case (flaw)
        F_CLAMP: begin
          case ($urandom_range(0, 2))
            0:       ulen = 16'($urandom_range(0, UDP_HDR - 1));       // no clamp at all
            1:       ulen = 16'(UDP_HDR + $urandom_range(0, pay.size()));
            default: ulen = 16'($urandom_range(0, 65535));
          endcase
        end
        F_LONG_USER: ulen = 16'(UDP_HDR + $urandom_range(MIN_PAYLOAD, 9));
        F_HUGE:      ulen = 16'($urandom_range(0, UDP_HDR - 1));
        default: ;
      endcase

      // trailing capture past the udp length, dropped by the clamp on well-formed frames
      if (flaw == F_CLAMP || (flaw == F_NONE && $urandom_range(0, 9) < 3))
        repeat ($urandom_range(1, 4)) pay.push_back(8'($urandom_range(0, 255)));

      frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q.push_back(dport[15:8]);
      frame_q.push_back(dport[7:0]);
      frame_q.push_back(ulen[15:8]);
      frame_q.push_back(ulen[7:0]);
      frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q.push_back(8'($urandom_range(0, 255)));
      foreach (pay[i]) frame_q.push_back(pay[i]);

      // cut anywhere before the payload, header fields included
      if (flaw == F_TRUNC) begin
        cut = $urandom_range(1, cur_link + OFS_PAYLOAD - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end
  endtask

  // mostly well-formed knocks with random content, the rest broken or noise
  task automatic random_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)      build_frame(F_NONE);
    else if (r < 67) build_frame(F_CLAMP);
    else if (r < 72) build_frame(F_GARBAGE);
    else if (r < 77) build_frame(F_NOISE);
    else             build_frame(flaw_t'($urandom_range(F_PROTO, F_EMPTY_ENC)));
    send_frame();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset register values
    for (int f = F_NONE; f <= F_EMPTY_ENC; f++) begin
      build_frame(flaw_t'(f));
      send_frame();
    end
    // single byte frame and an all-zero frame
    frame_q = '{8'hff};
    send_frame();
    frame_q.delete();
    repeat (40) frame_q.push_back(8'h00);
    send_frame();

    // config sweep: extremes first, then random settings
    phase_no = 0;
    while (phase_no < 6 || bytes_sent < 500 || frames_sent < 60) begin
      case (phase_no)
        0:       set_config(5'd0, 16'hffff);
        1:       set_config(5'd31, 16'($urandom_range(0, 65535)));
        2:       set_config(5'd31, 16'd0);
        default: set_config(5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
      endcase
      calm = (phase_no == 2);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        if (phase_no == 3 && n == PHASE_FRAMES / 2) wait_drained();
        random_frame();
      end
      calm = 1'b0;
      phase_no++;
    end

    // one frame long enough to saturate the byte position
    set_config(5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
    build_frame(F_HUGE);
    send_frame();
    build_frame(F_NONE);
    send_frame();

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
